@@ hdl/line_rect_clipper_assert.svh @@
// ----------------------------------------------------------------------------
// line_rect_clipper_assert: assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_RECT_CLIPPER_ASSERT_SVH
`define LINE_RECT_CLIPPER_ASSERT_SVH
`ifndef SYNTH
`define LRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_rect_clipper check failed");
`define LRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_rect_clipper check failed");
`else
`define LRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/lrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_pkg: line clipper types and constants
// Widths, word types and the edge move shared by the clipper stages.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int COORD_BITS          = 15;
  localparam int SLOPE_FRACTION_BITS = 16;

  localparam int CW  = COORD_BITS;
  localparam int FB  = SLOPE_FRACTION_BITS;
  localparam int DW  = CW + 1;
  localparam int EW  = CW + 2;
  localparam int DDW = CW + 3;
  localparam int QW  = CW + FB;
  localparam int SW  = QW + 1;
  localparam int PW  = DDW + SW;
  localparam int FW  = PW - FB + 1;

  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_LAT    = DIV_STAGES + 1;
  localparam int CORR_LAT   = 2;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [DW-1:0]  delta_t;
  typedef logic signed [EW-1:0]  edge_t;
  typedef logic signed [DDW-1:0] dist_t;
  typedef logic        [CW-1:0]  mag_t;
  typedef logic        [QW-1:0]  quo_t;
  typedef logic        [CW:0]    rem_t;
  typedef logic signed [SW-1:0]  slope_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [FW-1:0]  wide_t;

  typedef enum logic [1:0] {
    CFG_LEFT,
    CFG_TOP,
    CFG_WIDTH,
    CFG_HEIGHT
  } cfg_idx_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  typedef struct packed {
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
    logic   visible;
  } res_t;

  typedef struct packed {
    coord_t lo_x;
    edge_t  hi_x;
    coord_t lo_y;
    edge_t  hi_y;
  } bounds_t;

  typedef struct packed {
    logic   simple;
    logic   vis_s;
    edge_t  sx1;
    edge_t  sy1;
    edge_t  sx2;
    edge_t  sy2;
    edge_t  nx1;
    edge_t  nx2;
    dist_t  d1;
    dist_t  d2;
    coord_t y1;
    coord_t y2;
  } ctx_t;

  typedef struct packed {
    mag_t adx;
    mag_t ady;
    logic neg;
  } div_in_t;

  typedef struct packed {
    edge_t pos;
    dist_t travel;
  } move_t;

  function automatic move_t move_pt(input edge_t v, input coord_t lo, input edge_t hi);
    move_t m;
    if (v < edge_t'(lo)) begin
      m.pos    = edge_t'(lo);
      m.travel = dist_t'(lo) - dist_t'(v);
    end else if (v > hi) begin
      m.pos    = hi;
      m.travel = dist_t'(hi) - dist_t'(v);
    end else begin
      m.pos    = v;
      m.travel = '0;
    end
    return m;
  endfunction

endpackage

@@ hdl/lrc_if.sv @@
// ----------------------------------------------------------------------------
// lrc_if: clipper stream interfaces
// Segment and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrc_seg_if import lrc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrc_res_if import lrc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t clipped_start_x;
  coord_t clipped_start_y;
  coord_t clipped_end_x;
  coord_t clipped_end_y;
  logic   visible;

  modport source (output valid, clipped_start_x, clipped_start_y, clipped_end_x,
                  clipped_end_y, visible, input ready);
  modport sink (input valid, clipped_start_x, clipped_start_y, clipped_end_x,
                clipped_end_y, visible, output ready);
endinterface

@@ hdl/lrc_div.sv @@
// ----------------------------------------------------------------------------
// lrc_div: pipelined slope divider
// Restoring division of num * 2^FB by den, DIV_STEP quotient bits per stage,
// sign applied in a last stage; quotient truncated toward zero.
// ----------------------------------------------------------------------------
module lrc_div import lrc_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  mag_t   num,
  input  mag_t   den,
  input  logic   neg,
  output slope_t quo
);

  rem_t rem_q [DIV_STAGES];
  quo_t dq_q  [DIV_STAGES];
  mag_t den_q [DIV_STAGES];
  logic neg_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    rem_t r_in;
    quo_t q_in;
    mag_t d_in;
    logic n_in;
    rem_t r_out;
    quo_t q_out;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign q_in = {num, {FB{1'b0}}};
      assign d_in = den;
      assign n_in = neg;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign q_in = dq_q[s-1];
      assign d_in = den_q[s-1];
      assign n_in = neg_q[s-1];
    end

    always_comb begin
      rem_t r;
      quo_t q;
      r = r_in;
      q = q_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        if (s * DIV_STEP + j < QW) begin
          r = {r[CW-1:0], q[QW-1]};
          q = {q[QW-2:0], 1'b0};
          if (r >= rem_t'(d_in)) begin
            r    = r - rem_t'(d_in);
            q[0] = 1'b1;
          end
        end
      end
      r_out = r;
      q_out = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= r_out;
        dq_q[s]  <= q_out;
        den_q[s] <= d_in;
        neg_q[s] <= n_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg_q[DIV_STAGES-1] ? -slope_t'(dq_q[DIV_STAGES-1])
                                 : slope_t'(dq_q[DIV_STAGES-1]);
    end
  end

endmodule

@@ hdl/lrc_corr.sv @@
// ----------------------------------------------------------------------------
// lrc_corr: slope correction unit
// Multiply the moved distance by the slope, then add the floored product
// to the other coordinate. Two register stages.
// ----------------------------------------------------------------------------
module lrc_corr import lrc_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  wide_t  base,
  input  dist_t  travel,
  input  slope_t slope,
  output wide_t  sum
);

  prod_t prod_q;
  wide_t base_q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q <= travel * slope;
      base_q <= base;
      sum    <= base_q + wide_t'(prod_q >>> FB);
    end
  end

endmodule

@@ hdl/lrc_front.sv @@
// ----------------------------------------------------------------------------
// lrc_front: segment classification stage
// Sort vertical, horizontal and general segments, reject trivially, clamp
// the axis-aligned cases and set up the x edge move and divider operands.
// ----------------------------------------------------------------------------
module lrc_front import lrc_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  seg_t    seg,
  input  bounds_t bnd,
  output ctx_t    ctx,
  output div_in_t dvi
);

  ctx_t    ctx_next;
  div_in_t dvi_next;

  function automatic edge_t clamp_c(input coord_t v, input coord_t lo, input edge_t hi);
    edge_t r;
    if (edge_t'(v) < edge_t'(lo)) r = edge_t'(lo);
    else if (edge_t'(v) > hi) r = hi;
    else r = edge_t'(v);
    return r;
  endfunction

  always_comb begin
    delta_t         dx;
    delta_t         dy;
    logic [DW-1:0]  ax;
    logic [DW-1:0]  ay;
    logic           lx1, lx2, gx1, gx2, ly1, ly2, gy1, gy2;
    logic           vert, horz, rej;
    edge_t          cx1, cx2, cy1, cy2;
    move_t          m1, m2;

    dx = delta_t'(seg.end_x) - delta_t'(seg.start_x);
    dy = delta_t'(seg.end_y) - delta_t'(seg.start_y);
    ax = dx[DW-1] ? -dx : dx;
    ay = dy[DW-1] ? -dy : dy;

    lx1 = seg.start_x < bnd.lo_x;
    lx2 = seg.end_x < bnd.lo_x;
    gx1 = edge_t'(seg.start_x) > bnd.hi_x;
    gx2 = edge_t'(seg.end_x) > bnd.hi_x;
    ly1 = seg.start_y < bnd.lo_y;
    ly2 = seg.end_y < bnd.lo_y;
    gy1 = edge_t'(seg.start_y) > bnd.hi_y;
    gy2 = edge_t'(seg.end_y) > bnd.hi_y;

    vert = seg.start_x == seg.end_x;
    horz = !vert && (seg.start_y == seg.end_y);

    if (vert) rej = (ly1 && ly2) || (gy1 && gy2) || lx1 || gx1;
    else if (horz) rej = (lx1 && lx2) || (gx1 && gx2) || ly1 || gy1;
    else rej = (lx1 && lx2) || (gx1 && gx2) || (ly1 && ly2) || (gy1 && gy2);

    cx1 = clamp_c(seg.start_x, bnd.lo_x, bnd.hi_x);
    cx2 = clamp_c(seg.end_x, bnd.lo_x, bnd.hi_x);
    cy1 = clamp_c(seg.start_y, bnd.lo_y, bnd.hi_y);
    cy2 = clamp_c(seg.end_y, bnd.lo_y, bnd.hi_y);

    m1 = move_pt(edge_t'(seg.start_x), bnd.lo_x, bnd.hi_x);
    m2 = move_pt(edge_t'(seg.end_x), bnd.lo_x, bnd.hi_x);

    ctx_next.simple = vert || horz || rej;
    ctx_next.vis_s  = 1'b0;
    ctx_next.sx1    = edge_t'(seg.start_x);
    ctx_next.sy1    = edge_t'(seg.start_y);
    ctx_next.sx2    = edge_t'(seg.end_x);
    ctx_next.sy2    = edge_t'(seg.end_y);
    if (!rej && vert) begin
      ctx_next.sy1   = cy1;
      ctx_next.sy2   = cy2;
      ctx_next.vis_s = cy1 != cy2;
    end else if (!rej && horz) begin
      ctx_next.sx1   = cx1;
      ctx_next.sx2   = cx2;
      ctx_next.vis_s = cx1 != cx2;
    end
    ctx_next.nx1 = m1.pos;
    ctx_next.nx2 = m2.pos;
    ctx_next.d1  = m1.travel;
    ctx_next.d2  = m2.travel;
    ctx_next.y1  = seg.start_y;
    ctx_next.y2  = seg.end_y;

    dvi_next.adx = ax[CW-1:0];
    dvi_next.ady = ay[CW-1:0];
    dvi_next.neg = dx[DW-1] ^ dy[DW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx <= ctx_next;
      dvi <= dvi_next;
    end
  end

endmodule

@@ hdl/line_rect_clipper.sv @@
// ----------------------------------------------------------------------------
// line_rect_clipper: line segment clipper
// Path: entry register, front stage, dividers, y correction, y edge move, x correction, result buffer.
// Throughput: one segment per cycle while the result buffer can take it, set by the slope dividers, which
// retire 4 quotient bits per stage over 8 stages, and the two multiply stages.
// Reset: clip registers return to 0, the pipeline and result buffer empty.
// ----------------------------------------------------------------------------
`include "line_rect_clipper_assert.svh"

module line_rect_clipper import lrc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  cfg_idx_t     cfg_index,
  input  logic [CW-1:0] cfg_data,
  lrc_seg_if.sink      seg,
  lrc_res_if.source    res
);

  coord_t  cfg_left;
  coord_t  cfg_top;
  mag_t    cfg_width;
  mag_t    cfg_height;
  bounds_t bnd;

  logic    en;
  logic    v0;
  seg_t    s0;
  logic    v1;
  ctx_t    ctx1;
  div_in_t dvi1;
  slope_t  slx;
  slope_t  sly;

  logic    va  [DIV_LAT];
  ctx_t    ca  [DIV_LAT];
  wide_t   ys1;
  wide_t   ys2;
  logic    vb  [CORR_LAT];
  ctx_t    cb  [CORR_LAT];
  slope_t  slyb [CORR_LAT];

  move_t   mv1;
  move_t   mv2;
  logic    ve;
  ctx_t    ce;
  edge_t   ny1e;
  edge_t   ny2e;
  dist_t   dy1e;
  dist_t   dy2e;
  slope_t  slye;

  wide_t   xf1;
  wide_t   xf2;
  logic    vf  [CORR_LAT];
  ctx_t    cf  [CORR_LAT];
  edge_t   ny1f [CORR_LAT];
  edge_t   ny2f [CORR_LAT];

  res_t    res_next;
  res_t    fifo [2];
  logic    wp;
  logic    rp;
  logic [1:0] fcnt;
  logic    push;
  logic    pop;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v > wide_t'(COORD_MAX)) r = COORD_MAX;
    else if (v < wide_t'(COORD_MIN)) r = COORD_MIN;
    else r = v[CW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_left   <= '0;
      cfg_top    <= '0;
      cfg_width  <= '0;
      cfg_height <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LEFT:   cfg_left   <= cfg_data;
        CFG_TOP:    cfg_top    <= cfg_data;
        CFG_WIDTH:  cfg_width  <= cfg_data;
        CFG_HEIGHT: cfg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bnd.lo_x = cfg_left;
    bnd.hi_x = edge_t'(cfg_left) + edge_t'(cfg_width) - edge_t'(1);
    bnd.lo_y = cfg_top;
    bnd.hi_y = edge_t'(cfg_top) + edge_t'(cfg_height) - edge_t'(1);
  end

  assign en        = (fcnt != 2'd2) || res.ready;
  assign seg.ready = en;

  // entry register
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= seg.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.start_x <= seg.start_x;
      s0.start_y <= seg.start_y;
      s0.end_x   <= seg.end_x;
      s0.end_y   <= seg.end_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end

  lrc_front u_front (
    .clk (clk),
    .en  (en),
    .seg (s0),
    .bnd (bnd),
    .ctx (ctx1),
    .dvi (dvi1)
  );

  lrc_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (dvi1.ady),
    .den (dvi1.adx),
    .neg (dvi1.neg),
    .quo (slx)
  );

  lrc_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (dvi1.adx),
    .den (dvi1.ady),
    .neg (dvi1.neg),
    .quo (sly)
  );

  // carry context alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) va[i] <= 1'b0;
    end else if (en) begin
      va[0] <= v1;
      for (int i = 1; i < DIV_LAT; i++) va[i] <= va[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca[0] <= ctx1;
      for (int i = 1; i < DIV_LAT; i++) ca[i] <= ca[i-1];
    end
  end

  // x edges: correct y
  lrc_corr u_corr_y1 (
    .clk    (clk),
    .en     (en),
    .base   (wide_t'(ca[DIV_LAT-1].y1)),
    .travel (ca[DIV_LAT-1].d1),
    .slope  (slx),
    .sum    (ys1)
  );

  lrc_corr u_corr_y2 (
    .clk    (clk),
    .en     (en),
    .base   (wide_t'(ca[DIV_LAT-1].y2)),
    .travel (ca[DIV_LAT-1].d2),
    .slope  (slx),
    .sum    (ys2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORR_LAT; i++) vb[i] <= 1'b0;
    end else if (en) begin
      vb[0] <= va[DIV_LAT-1];
      for (int i = 1; i < CORR_LAT; i++) vb[i] <= vb[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb[0]   <= ca[DIV_LAT-1];
      slyb[0] <= sly;
      for (int i = 1; i < CORR_LAT; i++) begin
        cb[i]   <= cb[i-1];
        slyb[i] <= slyb[i-1];
      end
    end
  end

  // y edges: move endpoints
  always_comb begin
    edge_t y1n;
    edge_t y2n;
    y1n = ys1[EW-1:0];
    y2n = ys2[EW-1:0];
    mv1 = move_pt(y1n, bnd.lo_y, bnd.hi_y);
    mv2 = move_pt(y2n, bnd.lo_y, bnd.hi_y);
  end

  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else if (en) ve <= vb[CORR_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ce   <= cb[CORR_LAT-1];
      ny1e <= mv1.pos;
      ny2e <= mv2.pos;
      dy1e <= mv1.travel;
      dy2e <= mv2.travel;
      slye <= slyb[CORR_LAT-1];
    end
  end

  // y edges: correct x
  lrc_corr u_corr_x1 (
    .clk    (clk),
    .en     (en),
    .base   (wide_t'(ce.nx1)),
    .travel (dy1e),
    .slope  (slye),
    .sum    (xf1)
  );

  lrc_corr u_corr_x2 (
    .clk    (clk),
    .en     (en),
    .base   (wide_t'(ce.nx2)),
    .travel (dy2e),
    .slope  (slye),
    .sum    (xf2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORR_LAT; i++) vf[i] <= 1'b0;
    end else if (en) begin
      vf[0] <= ve;
      for (int i = 1; i < CORR_LAT; i++) vf[i] <= vf[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf[0]   <= ce;
      ny1f[0] <= ny1e;
      ny2f[0] <= ny2e;
      for (int i = 1; i < CORR_LAT; i++) begin
        cf[i]   <= cf[i-1];
        ny1f[i] <= ny1f[i-1];
        ny2f[i] <= ny2f[i-1];
      end
    end
  end

  // select and saturate
  always_comb begin
    if (cf[CORR_LAT-1].simple) begin
      res_next.clipped_start_x = sat_coord(wide_t'(cf[CORR_LAT-1].sx1));
      res_next.clipped_start_y = sat_coord(wide_t'(cf[CORR_LAT-1].sy1));
      res_next.clipped_end_x   = sat_coord(wide_t'(cf[CORR_LAT-1].sx2));
      res_next.clipped_end_y   = sat_coord(wide_t'(cf[CORR_LAT-1].sy2));
      res_next.visible         = cf[CORR_LAT-1].vis_s;
    end else begin
      res_next.clipped_start_x = sat_coord(xf1);
      res_next.clipped_start_y = sat_coord(wide_t'(ny1f[CORR_LAT-1]));
      res_next.clipped_end_x   = sat_coord(xf2);
      res_next.clipped_end_y   = sat_coord(wide_t'(ny2f[CORR_LAT-1]));
      res_next.visible         = (xf1 != xf2) || (ny1f[CORR_LAT-1] != ny2f[CORR_LAT-1]);
    end
  end

  // result buffer
  assign push = en && vf[CORR_LAT-1];
  assign pop  = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fcnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fcnt <= fcnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= res_next;
  end

  assign res.valid           = fcnt != 2'd0;
  assign res.clipped_start_x = fifo[rp].clipped_start_x;
  assign res.clipped_start_y = fifo[rp].clipped_start_y;
  assign res.clipped_end_x   = fifo[rp].clipped_end_x;
  assign res.clipped_end_y   = fifo[rp].clipped_end_y;
  assign res.visible         = fifo[rp].visible;

  `LRC_ASSERT_IMP(a_no_overflow, clk, rst, push && (fcnt == 2'd2), pop)
  `LRC_ASSERT_NEXT(a_stall_hold, clk, rst, !en, $stable(vf[CORR_LAT-1]))
  `LRC_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, fcnt == $past(fcnt) + 2'd1)

endmodule
